// ===== hdl/asu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_pkg
// Shared types and constants of the Adam step-update engine.
// ----------------------------------------------------------------------------
package asu_pkg;

	localparam int PARAM_COUNT = 1024;
	localparam int ADDR_W      = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int INDEX_W     = 10;

	localparam int FQ_DEPTH    = 4;
	localparam int FQ_AW       = $clog2(FQ_DEPTH);
	localparam int MID_DEPTH   = 4;
	localparam int MID_AW      = $clog2(MID_DEPTH);

	localparam int DIV_STEPS   = 48;
	localparam int SQRT_STEPS  = 32;
	localparam int QUO_STEPS   = 31;

	localparam logic [16:0] ONE_Q16 = 17'h1_0000;

	typedef enum logic [1:0] {
		REG_LR  = 2'd0,
		REG_B1  = 2'd1,
		REG_B2  = 2'd2,
		REG_EPS = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [23:0] lr;
		logic [15:0] b1;
		logic [15:0] b2;
		logic [15:0] eps;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   addr;
		logic signed [31:0]  grad;
		logic [31:0]         sq;
		logic [16:0]         d1;
		logic [16:0]         d2;
	} fq_entry_t;

	typedef struct packed {
		logic signed [31:0]  m;
		logic [31:0]         v;
		logic [16:0]         d1;
		logic [16:0]         d2;
	} mid_entry_t;

endpackage

// ===== hdl/asu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module asu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/asu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_front
// Accept gradient transactions, advance beta powers, form correction
// divisors and the clipped square, and queue the work for the back end.
// ----------------------------------------------------------------------------
module asu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  asu_pkg::cfg_t     cfg,
	input  logic              clearing,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [47:0]       s_tdata,   // param_index[9:0], grad_value[41:10], zero pad
	input  logic              s_tuser,   // starts_tensor
	input  logic              pop,
	output logic              head_valid,
	output asu_pkg::fq_entry_t head
);
	import asu_pkg::*;

	localparam int RECIP = ((1 << 20) + PARAM_COUNT - 1) / PARAM_COUNT;

	fq_entry_t          fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0]   wr_q, rd_q;
	logic [FQ_AW:0]     cnt_q;
	logic [16:0]        p1_q, p2_q;

	logic               accept;
	logic [INDEX_W-1:0] idx;
	logic signed [31:0] grad;
	logic [32:0]        p1_prod, p2_prod;
	logic [16:0]        p1_nx, p2_nx, d1, d2;
	logic [31:0]        gmag, sq;
	logic [63:0]        gsq;
	logic [29:0]        mod_prod;
	logic [9:0]         mod_q;
	logic [19:0]        mod_back;
	logic [INDEX_W-1:0] mod_r;
	fq_entry_t          entry;

	assign s_tready   = (cnt_q != (FQ_AW+1)'(FQ_DEPTH)) && !clearing;
	assign accept     = s_tvalid && s_tready;
	assign head_valid = (cnt_q != '0);
	assign head       = fq_q[rd_q];

	always_comb begin
		idx     = s_tdata[9:0];
		grad    = $signed(s_tdata[41:10]);
		p1_prod = p1_q * cfg.b1;
		p2_prod = p2_q * cfg.b2;
		p1_nx   = s_tuser ? p1_prod[32:16] : p1_q;
		p2_nx   = s_tuser ? p2_prod[32:16] : p2_q;
		d1      = ONE_Q16 - p1_nx;
		d2      = ONE_Q16 - p2_nx;
		if (d1 == '0) begin
			d1 = 17'd1;
		end
		if (d2 == '0) begin
			d2 = 17'd1;
		end
		gmag = grad[31] ? 32'(-grad) : 32'(grad);
		gsq  = gmag * gmag;
		sq   = (gsq[63:48] != '0) ? 32'hFFFF_FFFF : gsq[47:16];
		mod_prod = 30'(30'(idx) * 30'(RECIP));
		mod_q    = mod_prod[29:20];
		mod_back = 20'(mod_q) * 20'(PARAM_COUNT);
		mod_r    = idx - mod_back[9:0];
		entry.addr = (PARAM_COUNT >= (1 << INDEX_W)) ? ADDR_W'(idx) : ADDR_W'(mod_r);
		entry.grad = grad;
		entry.sq   = sq;
		entry.d1   = d1;
		entry.d2   = d2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
			p1_q  <= ONE_Q16;
			p2_q  <= ONE_Q16;
		end else begin
			if (accept) begin
				wr_q <= wr_q + FQ_AW'(1);
				p1_q <= p1_nx;
				p2_q <= p2_nx;
			end
			if (pop) begin
				rd_q <= rd_q + FQ_AW'(1);
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + (FQ_AW+1)'(1);
			end else if (!accept && pop) begin
				cnt_q <= cnt_q - (FQ_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fq_q[wr_q] <= entry;
		end
	end

endmodule

// ===== hdl/asu_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_div
// Pipelined restoring divider, 48-bit dividend by 17-bit divisor, one
// quotient bit per stage.
// ----------------------------------------------------------------------------
module asu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [47:0] num,
	input  logic [16:0] den,
	output logic        out_vld,
	output logic [47:0] quo
);
	import asu_pkg::*;

	logic        vld_p [DIV_STEPS+1];
	logic [16:0] rem_p [DIV_STEPS+1];
	logic [47:0] nq_p  [DIV_STEPS+1];
	logic [16:0] den_p [DIV_STEPS+1];

	assign vld_p[0] = in_vld;
	assign rem_p[0] = '0;
	assign nq_p[0]  = num;
	assign den_p[0] = den;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [17:0] trial;
		logic        ge;

		assign trial = {rem_p[k], nq_p[k][47]};
		assign ge    = (trial >= {1'b0, den_p[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k+1] <= 1'b0;
			end else if (en) begin
				vld_p[k+1] <= vld_p[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_p[k+1] <= ge ? 17'(trial - {1'b0, den_p[k]}) : trial[16:0];
				nq_p[k+1]  <= {nq_p[k][46:0], ge};
				den_p[k+1] <= den_p[k];
			end
		end
	end

	assign out_vld = vld_p[DIV_STEPS];
	assign quo     = nq_p[DIV_STEPS];

endmodule

// ===== hdl/asu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_back
// Moment read-modify-write, bias-correction dividers, square root and the
// final saturating divide, ending in the output register.
// ----------------------------------------------------------------------------
module asu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  asu_pkg::cfg_t      cfg,
	input  logic               head_valid,
	input  asu_pkg::fq_entry_t head,
	output logic               pop,
	output logic               clearing,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata   // update_value
);
	import asu_pkg::*;

	// clearing pass
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_W'(1);
			if (clr_q == ADDR_W'(PARAM_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	assign clearing = clearing_q;

	// read-modify-write stage
	logic              valid_s1;
	fq_entry_t         entry_s1;
	logic [63:0]       rdata;
	logic              fwd_valid_q;
	logic [ADDR_W-1:0] fwd_addr_q;
	logic signed [31:0] fwd_m_q;
	logic [31:0]       fwd_v_q;

	logic signed [31:0] m_old, mnew;
	logic [31:0]       v_old, vnew;
	logic [16:0]       omb1, omb2;
	logic signed [48:0] mp1;
	logic signed [49:0] mp2, msum;
	logic [47:0]       vp1;
	logic [48:0]       vp2;
	logic [49:0]       vsum;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [63:0]       ram_wdata;

	mid_entry_t        mid_q [MID_DEPTH];
	logic [MID_AW-1:0] mwr_q, mrd_q;
	logic [MID_AW:0]   mcnt_q;
	logic              mpop, adv;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	assign adv  = !out_valid_q || m_tready;
	assign mpop = adv && (mcnt_q != '0);
	assign pop  = head_valid && !clearing_q &&
		((mcnt_q + (MID_AW+1)'(valid_s1)) <= (MID_AW+1)'(MID_DEPTH - 2));

	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == entry_s1.addr)) begin
			m_old = fwd_m_q;
			v_old = fwd_v_q;
		end else begin
			m_old = $signed(rdata[31:0]);
			v_old = rdata[63:32];
		end
		omb1 = ONE_Q16 - {1'b0, cfg.b1};
		omb2 = ONE_Q16 - {1'b0, cfg.b2};
		mp1  = m_old * $signed({1'b0, cfg.b1});
		mp2  = entry_s1.grad * $signed({1'b0, omb1});
		msum = {mp1[48], mp1} + mp2;
		mnew = msum[47:16];
		vp1  = v_old * cfg.b2;
		vp2  = entry_s1.sq * omb2;
		vsum = {2'b00, vp1} + {1'b0, vp2};
		vnew = vsum[47:16];
		if (clearing_q) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = valid_s1;
			ram_waddr = entry_s1.addr;
			ram_wdata = {vnew, mnew};
		end
	end

	asu_ram #(
		.WIDTH (64),
		.DEPTH (PARAM_COUNT)
	) u_moment_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head.addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			mwr_q       <= '0;
			mrd_q       <= '0;
			mcnt_q      <= '0;
		end else begin
			valid_s1    <= pop;
			fwd_valid_q <= valid_s1;
			if (valid_s1) begin
				mwr_q <= mwr_q + MID_AW'(1);
			end
			if (mpop) begin
				mrd_q <= mrd_q + MID_AW'(1);
			end
			if (valid_s1 && !mpop) begin
				mcnt_q <= mcnt_q + (MID_AW+1)'(1);
			end else if (!valid_s1 && mpop) begin
				mcnt_q <= mcnt_q - (MID_AW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_s1   <= head;
		fwd_addr_q <= entry_s1.addr;
		fwd_m_q    <= mnew;
		fwd_v_q    <= vnew;
		if (valid_s1) begin
			mid_q[mwr_q] <= '{m: mnew, v: vnew, d1: entry_s1.d1, d2: entry_s1.d2};
		end
	end

	// bias correction
	mid_entry_t   mh;
	logic         neg0;
	logic [31:0]  mmag0;
	logic         mdiv_vld, vdiv_vld;
	logic [47:0]  mhat, vhat;
	logic         neg_dl_q [DIV_STEPS];

	assign mh    = mid_q[mrd_q];
	assign neg0  = mh.m[31];
	assign mmag0 = neg0 ? 32'(-mh.m) : 32'(mh.m);

	asu_div u_mdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (mpop),
		.num     ({mmag0, 16'h0000}),
		.den     (mh.d1),
		.out_vld (mdiv_vld),
		.quo     (mhat)
	);

	asu_div u_vdiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_vld  (mpop),
		.num     ({mh.v, 16'h0000}),
		.den     (mh.d2),
		.out_vld (vdiv_vld),
		.quo     (vhat)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_dl_q[0] <= neg0;
			for (int k = 1; k < DIV_STEPS; k++) begin
				neg_dl_q[k] <= neg_dl_q[k-1];
			end
		end
	end

	// square root
	logic        sq_vld  [SQRT_STEPS+1];
	logic [33:0] sq_rem  [SQRT_STEPS+1];
	logic [31:0] sq_root [SQRT_STEPS+1];
	logic [63:0] sq_x    [SQRT_STEPS+1];
	logic [47:0] sq_mhat [SQRT_STEPS+1];
	logic        sq_neg  [SQRT_STEPS+1];

	assign sq_vld[0]  = mdiv_vld && vdiv_vld;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_x[0]    = {vhat, 16'h0000};
	assign sq_mhat[0] = mhat;
	assign sq_neg[0]  = neg_dl_q[DIV_STEPS-1];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		logic [35:0] tr, tt;
		logic        ge;

		assign tr = {sq_rem[k], sq_x[k][63:62]};
		assign tt = {2'b00, sq_root[k], 2'b01};
		assign ge = (tr >= tt);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (adv) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rem[k+1]  <= ge ? 34'(tr - tt) : tr[33:0];
				sq_root[k+1] <= {sq_root[k][30:0], ge};
				sq_x[k+1]    <= {sq_x[k][61:0], 2'b00};
				sq_mhat[k+1] <= sq_mhat[k];
				sq_neg[k+1]  <= sq_neg[k];
			end
		end
	end

	// scale and range check
	logic        vld_s2, neg_s2;
	logic [32:0] den_s2;
	logic [47:0] pplo_s2, pphi_s2;
	logic [32:0] den_c;
	logic        vld_s3, neg_s3, ovf_s3;
	logic [32:0] den_s3;
	logic [63:0] n_s3;
	logic [71:0] n_c;

	always_comb begin
		den_c = {1'b0, sq_root[SQRT_STEPS]} + {17'h0_0000, cfg.eps};
		if (den_c == '0) begin
			den_c = 33'd1;
		end
		n_c = {24'h00_0000, pplo_s2} + {pphi_s2, 24'h00_0000};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= sq_vld[SQRT_STEPS];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2  <= sq_neg[SQRT_STEPS];
			den_s2  <= den_c;
			pplo_s2 <= cfg.lr * sq_mhat[SQRT_STEPS][23:0];
			pphi_s2 <= cfg.lr * sq_mhat[SQRT_STEPS][47:24];
			neg_s3  <= neg_s2;
			den_s3  <= den_s2;
			n_s3    <= n_c[63:0];
			ovf_s3  <= (n_c >= {8'h00, den_s2, 31'h0000_0000});
		end
	end

	// final divide
	logic        fd_vld [QUO_STEPS+1];
	logic [63:0] fd_rem [QUO_STEPS+1];
	logic [32:0] fd_den [QUO_STEPS+1];
	logic [30:0] fd_q   [QUO_STEPS+1];
	logic        fd_ovf [QUO_STEPS+1];
	logic        fd_neg [QUO_STEPS+1];

	assign fd_vld[0] = vld_s3;
	assign fd_rem[0] = n_s3;
	assign fd_den[0] = den_s3;
	assign fd_q[0]   = '0;
	assign fd_ovf[0] = ovf_s3;
	assign fd_neg[0] = neg_s3;

	for (genvar j = 0; j < QUO_STEPS; j++) begin : g_quo
		logic [63:0] dsh;
		logic        ge;

		assign dsh = 64'(fd_den[j]) << (QUO_STEPS - 1 - j);
		assign ge  = (fd_rem[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				fd_vld[j+1] <= 1'b0;
			end else if (adv) begin
				fd_vld[j+1] <= fd_vld[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				fd_rem[j+1] <= ge ? (fd_rem[j] - dsh) : fd_rem[j];
				fd_den[j+1] <= fd_den[j];
				fd_q[j+1]   <= {fd_q[j][29:0], ge};
				fd_ovf[j+1] <= fd_ovf[j];
				fd_neg[j+1] <= fd_neg[j];
			end
		end
	end

	// output register
	logic [31:0] res;

	always_comb begin
		if (fd_ovf[QUO_STEPS]) begin
			res = fd_neg[QUO_STEPS] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (fd_neg[QUO_STEPS]) begin
			res = 32'h0000_0000 - {1'b0, fd_q[QUO_STEPS]};
		end else begin
			res = {1'b0, fd_q[QUO_STEPS]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= fd_vld[QUO_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== hdl/adam_step_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_step_update
// Adam parameter-update engine: one gradient element in, one saturated
// Q16.16 update out, with moment stores and an APB register port.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while the output is not stalled,
// set by the pipelined bias-correction dividers, square root and final
// divider (one bit per stage).
// Reset: after arst_n releases, a clearing pass zeroes the 1024 moment
// entries, one per cycle; s_tready stays low until the pass has ended.
// ----------------------------------------------------------------------------
module adam_step_update (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // param_index[9:0], grad_value[41:10], zero pad
	input  logic        s_tuser,   // starts_tensor
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // update_value[31:0]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import asu_pkg::*;

	cfg_t       cfg_q;
	reg_idx_t   ridx;
	logic       cfg_wr;
	logic       clearing, pop, head_valid;
	fq_entry_t  head;

	assign pready = 1'b1;
	assign ridx   = reg_idx_t'(paddr[3:2]);
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lr  <= 24'd65536;
			cfg_q.b1  <= 16'd58982;
			cfg_q.b2  <= 16'd65470;
			cfg_q.eps <= 16'd1;
		end else if (cfg_wr) begin
			unique case (ridx)
				REG_LR:  cfg_q.lr  <= pwdata[23:0];
				REG_B1:  cfg_q.b1  <= pwdata[15:0];
				REG_B2:  cfg_q.b2  <= pwdata[15:0];
				REG_EPS: cfg_q.eps <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			REG_LR:  prdata = {8'h00, cfg_q.lr};
			REG_B1:  prdata = {16'h0000, cfg_q.b1};
			REG_B2:  prdata = {16'h0000, cfg_q.b2};
			REG_EPS: prdata = {16'h0000, cfg_q.eps};
			default: prdata = '0;
		endcase
	end

	asu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.clearing   (clearing),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	asu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

// ===== hdl/asu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asu_chk
// Port-level checks for the Adam step-update engine, bound to the top level.
// ----------------------------------------------------------------------------
module asu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [47:0] s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	import asu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output transaction changed while stalled");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !s_tready)
		else $error("input taken during moment clearing");

	a_lr_readback: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite && pready && paddr[3:2] == REG_LR)
		##1 (psel && !pwrite && paddr[3:2] == REG_LR)
		|-> prdata == {8'h00, $past(pwdata[23:0])})
		else $error("learning rate readback mismatch");

	a_no_out_in_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind adam_step_update asu_chk u_asu_chk (.*);

// ===== tb/adam_step_update_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_step_update_tb
// Self-checking testbench of the Adam step-update engine. A queue of gradient
// transactions feeds a clocked driver. A bit-exact predictor with its own
// moment stores and beta powers computes each update, and a clocked monitor
// compares every output transaction with the oldest predicted update. Several
// register settings are used, the extremes among them, and both sides of the
// stream idle in random bursts.
// ----------------------------------------------------------------------------
module adam_step_update_tb;
	import asu_pkg::*;

	localparam int LATENCY   = 116;
	localparam int WDOG_MAX  = 20000;
	localparam int DEPTH     = 1024;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	adam_step_update dut (.*);

	always #5 clk = ~clk;

	typedef struct packed {
		logic [9:0]  idx;
		logic [31:0] grad;
		logic        start;
	} grad_item_t;

	grad_item_t  pending_q[$];
	logic [31:0] update_q[$];

	logic [23:0] lr_r;
	logic [15:0] b1_r, b2_r, eps_r;
	logic signed [31:0] m_store [DEPTH];
	logic [31:0] v_store [DEPTH];
	logic [16:0] p1, p2;

	int  errors = 0;
	int  wdog = 0;
	bit  quiet = 0;
	bit  hold_rx = 0;
	bit  hold_tx = 0;
	int  tx_gap = 0;
	int  rx_gap = 0;

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [31:0] adam_update(grad_item_t it);
		logic signed [63:0] g, macc, mnew;
		logic [63:0] gmag, sq, vnew, d1, d2, mmag, mhat, vhat, root, den, q;
		logic [127:0] prod;
		logic neg;
		if (it.start) begin
			p1 = 17'((64'(p1) * b1_r) >> 16);
			p2 = 17'((64'(p2) * b2_r) >> 16);
		end
		g = 64'(signed'(it.grad));
		macc = 64'(m_store[it.idx]) * $signed({48'd0, b1_r})
			+ g * $signed(64'(65536 - int'(b1_r)));
		mnew = macc >>> 16;
		m_store[it.idx] = mnew[31:0];
		gmag = g < 0 ? 64'(-g) : 64'(g);
		sq = (gmag * gmag) >> 16;
		if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
		vnew = (64'(v_store[it.idx]) * b2_r + sq * (64'd65536 - b2_r)) >> 16;
		v_store[it.idx] = vnew[31:0];
		d1 = 64'd65536 - p1;
		d2 = 64'd65536 - p2;
		if (d1 == 0) d1 = 1;
		if (d2 == 0) d2 = 1;
		neg = mnew < 0;
		mmag = neg ? 64'(-mnew) : 64'(mnew);
		mhat = (mmag << 16) / d1;
		vhat = (vnew << 16) / d2;
		root = isqrt(vhat << 16);
		den = root + eps_r;
		if (den == 0) den = 1;
		prod = 128'(mhat) * lr_r;
		q = (prod / den > 128'h1_0000_0000) ? 64'h1_0000_0000 : 64'(prod / den);
		if (neg) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return 32'(64'd0 - q);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return q[31:0];
	endfunction

	task automatic write_reg(reg_idx_t r, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = 4'(r) << 2; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (r)
			REG_LR:  lr_r  = val[23:0];
			REG_B1:  b1_r  = val[15:0];
			REG_B2:  b2_r  = val[15:0];
			REG_EPS: eps_r = val[15:0];
		endcase
	endtask

	task automatic push_item(logic [9:0] idx, logic [31:0] grad, logic start);
		grad_item_t it;
		it.idx = idx; it.grad = grad; it.start = start;
		pending_q.push_back(it);
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || update_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_grad();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
		endcase
	endfunction

	task automatic random_tensors(int n, int span);
		int left;
		int len;
		logic [9:0] base;
		left = n;
		while (left > 0) begin
			len = $urandom_range(1, 24);
			base = 10'($urandom_range(0, DEPTH - 1));
			for (int k = 0; k < len && left > 0; k++) begin
				if ($urandom_range(0, 9) == 0)
					push_item(10'($urandom()), rand_grad(), 1'($urandom_range(0, 1)));
				else
					push_item(10'(base + k % span), rand_grad(), k == 0);
				left--;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !s_tready) begin
			end else if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				tx_gap = $urandom_range(0, 6);
				s_tvalid <= 1'b0;
			end else if (!hold_tx && pending_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata  <= {6'd0, pending_q[0].grad, pending_q[0].idx};
				s_tuser  <= pending_q[0].start;
			end else begin
				s_tvalid <= 1'b0;
			end
			if (hold_rx) begin
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rx_gap = $urandom_range(0, 6);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		logic [31:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				update_q.push_back(adam_update(pending_q.pop_front()));
			end
			if (m_tvalid && m_tready) begin
				if (update_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected update %h", m_tdata);
				end else begin
					want = update_q.pop_front();
					if (want !== m_tdata) begin
						errors++;
						if (errors <= 10)
							$display("update mismatch: expected %h actual %h", want, m_tdata);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(pending_q.size() == 0 && update_q.size() == 0)) wdog = 0;
			else wdog++;
			if (wdog >= WDOG_MAX) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		lr_r = 24'd65536; b1_r = 16'd58982; b2_r = 16'd65470; eps_r = 16'd1;
		p1 = ONE_Q16; p2 = ONE_Q16;
		for (int i = 0; i < DEPTH; i++) begin
			m_store[i] = '0;
			v_store[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (1100) @(posedge clk);

		push_item(10'd0, 32'h0001_0000, 1'b0);
		push_item(10'd1023, 32'h7FFF_FFFF, 1'b0);
		push_item(10'd5, 32'h8000_0000, 1'b1);
		push_item(10'd5, 32'h0000_0000, 1'b0);
		push_item(10'd6, 32'hFFFF_FFFF, 1'b0);
		push_item(10'd7, 32'h0000_0001, 1'b1);
		push_item(10'd1023, 32'h8000_0000, 1'b0);
		push_item(10'd0, 32'hFFFF_0000, 1'b1);
		push_item(10'd512, 32'h5555_5555, 1'b0);
		push_item(10'd341, 32'hAAAA_AAAA, 1'b1);
		drain();

		write_reg(REG_EPS, 32'd0);
		push_item(10'd900, 32'h0000_0000, 1'b1);
		push_item(10'd901, 32'h0000_0000, 1'b0);
		push_item(10'd902, 32'h0010_0000, 1'b0);
		drain();

		write_reg(REG_LR, 32'hFFFF_FFFF);
		write_reg(REG_B1, 32'h0000_FFFF);
		write_reg(REG_B2, 32'd0);
		write_reg(REG_EPS, 32'h0000_FFFF);
		push_item(10'd10, 32'h7FFF_FFFF, 1'b1);
		push_item(10'd11, 32'h8000_0000, 1'b0);
		push_item(10'd10, 32'h0000_0100, 1'b1);
		random_tensors(150, 8);
		drain();

		write_reg(REG_LR, 32'd0);
		write_reg(REG_B1, 32'd0);
		write_reg(REG_B2, 32'h0000_FFFF);
		write_reg(REG_EPS, 32'd1);
		random_tensors(60, 4);
		drain();

		write_reg(REG_LR, $urandom());
		write_reg(REG_B1, $urandom_range(50000, 65535));
		write_reg(REG_B2, $urandom_range(60000, 65535));
		write_reg(REG_EPS, $urandom_range(0, 300));
		hold_rx = 1;
		random_tensors(200, 16);
		repeat (400) @(posedge clk);
		hold_rx = 0;
		while (pending_q.size() != 0) @(posedge clk);
		hold_tx = 1;
		while (update_q.size() != 0) @(posedge clk);
		hold_tx = 0;
		random_tensors(150, 32);
		drain();

		write_reg(REG_LR, 32'd65536);
		write_reg(REG_B1, 32'd58982);
		write_reg(REG_B2, 32'd65470);
		write_reg(REG_EPS, 32'd1);
		random_tensors(120, 64);
		quiet = 1;
		random_tensors(150, 64);
		drain();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
